[hdl/rgbsat_pkg.sv]
package rgbsat_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int CoordW    = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int AddrW     = CoordW + RowW;
  localparam int DimW      = 9;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusOutside = 2'd1;
  localparam logic [1:0] StatusNotDone = 2'd2;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] query_x;
    logic [7:0] query_y;
    logic [3:0] size_exponent;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] sum_red;
    logic [23:0] sum_green;
    logic [23:0] sum_blue;
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
    logic [31:0] deviation_sum;
  } out_item_t;

  // one row of all six tables
  typedef struct packed {
    logic [23:0] s_r;
    logic [23:0] s_g;
    logic [23:0] s_b;
    logic [31:0] q_r;
    logic [31:0] q_g;
    logic [31:0] q_b;
  } sat_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,     // read left, up, diag
    ST_LD_WR,
    ST_Q_RD,      // read four corners
    ST_Q_MUL,     // square one channel sum per cycle
    ST_Q_DONE,
    ST_Q_FIN      // fold the last square, then form the deviation
  } state_t;

endpackage

[hdl/rgbsat_ram.sv]
module rgbsat_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [rgbsat_pkg::AddrW-1:0]  waddr,
  input  rgbsat_pkg::sat_word_t         wdata,
  input  logic [rgbsat_pkg::AddrW-1:0]  raddr,
  output rgbsat_pkg::sat_word_t         rdata
);

  rgbsat_pkg::sat_word_t mem [0:(1 << rgbsat_pkg::AddrW)-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[hdl/rgb_integral_image_square_stats_unit.sv]
// Load: busy through three table reads, a read-latency wait and one write.
// Query: on a status error busy only for the check; a valid square is busy through
// the check, four corner reads through the single table read port, three squarings
// on one shared multiplier, folding the last square and forming the deviation.
// Result strobe out_valid is high in the first idle cycle; the receiver cannot
// stall. A new item is taken only while idle, after the last one is done. Sync
// active-low reset: 256x256, load position 0, image incomplete.
module rgb_integral_image_square_stats_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  rgbsat_pkg::in_item_t   in_item,
  output logic                   out_valid,
  output rgbsat_pkg::out_item_t  out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [8:0]             cfg_data
);

  rgbsat_pkg::state_t state_r, state_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [rgbsat_pkg::DimW-1:0] width_r, height_r;
  logic [rgbsat_pkg::CoordW-1:0] col_r;
  logic [rgbsat_pkg::RowW-1:0]   row_r;
  logic        done_r;
  rgbsat_pkg::in_item_t item_r;
  rgbsat_pkg::sat_word_t acc_r, rdata;
  logic        rd_ok_r;   // previous read address was a real entry
  logic [rgbsat_pkg::AddrW-1:0] raddr;
  logic        rd_ok;
  logic        we;
  logic [63:0] sq_acc_r;
  logic [23:0] mul_a;
  logic [47:0] mul_p_r;
  logic        mul_v_r;
  rgbsat_pkg::out_item_t res_r;
  logic        res_v_r, res_v_nxt;

  assign busy      = (state_r != rgbsat_pkg::ST_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = res_v_r;
  assign out_item  = res_r;

  logic [8:0] side, qx1, qy1;
  logic [3:0] k;
  logic [4:0] sh;
  assign k    = item_r.size_exponent;
  assign side = 9'd1 << k[3:0];
  assign sh   = {k, 1'b0};
  assign qx1  = {1'b0, item_r.query_x} + side - 9'd1;
  assign qy1  = {1'b0, item_r.query_y} + side - 9'd1;

  // read address: load reads left,up,diag; query reads a,b,c,d
  always_comb begin
    raddr = '0;
    rd_ok = 1'b0;
    if (state_r == rgbsat_pkg::ST_LD_RD) begin
      case (step_r)
        2'd0: begin raddr = {row_r, col_r - 8'd1}; rd_ok = (col_r != '0); end
        2'd1: begin raddr = {row_r - 8'd1, col_r}; rd_ok = (row_r != '0); end
        2'd2: begin
          raddr = {row_r - 8'd1, col_r - 8'd1};
          rd_ok = (row_r != '0) && (col_r != '0);
        end
        default: ;
      endcase
    end else if (state_r == rgbsat_pkg::ST_Q_RD) begin
      case (step_r)
        2'd0: begin raddr = {qy1[7:0], qx1[7:0]}; rd_ok = 1'b1; end
        2'd1: begin
          raddr = {item_r.query_y - 8'd1, qx1[7:0]};
          rd_ok = (item_r.query_y != '0);
        end
        2'd2: begin
          raddr = {qy1[7:0], item_r.query_x - 8'd1};
          rd_ok = (item_r.query_x != '0);
        end
        default: begin
          raddr = {item_r.query_y - 8'd1, item_r.query_x - 8'd1};
          rd_ok = (item_r.query_x != '0) && (item_r.query_y != '0);
        end
      endcase
    end
  end

  rgbsat_pkg::sat_word_t wdata;
  assign we = (state_r == rgbsat_pkg::ST_LD_WR);
  always_comb begin
    wdata.s_r = acc_r.s_r + 24'(item_r.red);
    wdata.s_g = acc_r.s_g + 24'(item_r.green);
    wdata.s_b = acc_r.s_b + 24'(item_r.blue);
    wdata.q_r = acc_r.q_r + 32'({8'd0, item_r.red} * {8'd0, item_r.red});
    wdata.q_g = acc_r.q_g + 32'({8'd0, item_r.green} * {8'd0, item_r.green});
    wdata.q_b = acc_r.q_b + 32'({8'd0, item_r.blue} * {8'd0, item_r.blue});
  end

  rgbsat_ram u_ram (
    .clk(clk), .we(we), .waddr({row_r, col_r}), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // add/subtract sign of the word arriving this cycle (step_r lags by one)
  logic sub_now;
  always_comb begin
    if (state_r == rgbsat_pkg::ST_LD_RD || state_r == rgbsat_pkg::ST_LD_WR)
      sub_now = (step_r == 2'd3) || (state_r == rgbsat_pkg::ST_LD_WR);
    else
      sub_now = (step_r == 2'd2) || (step_r == 2'd3);
  end
  logic take;
  assign take = rd_ok_r && ((state_r == rgbsat_pkg::ST_LD_RD && step_r != 2'd0) ||
                             state_r == rgbsat_pkg::ST_LD_WR ||
                             (state_r == rgbsat_pkg::ST_Q_RD && step_r != 2'd0) ||
                             state_r == rgbsat_pkg::ST_Q_MUL && step_r == 2'd0);

  // query check
  logic q_bad;
  assign q_bad = (k > 4'd8) || (10'(item_r.query_x) + 10'(side) > 10'(width_r)) ||
                 (10'(item_r.query_y) + 10'(side) > 10'(height_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 2'd1;
    case (state_r)
      rgbsat_pkg::ST_IDLE: begin
        step_nxt = '0;
        if (start) begin
          if (in_item.op == rgbsat_pkg::OpLoad) state_nxt = rgbsat_pkg::ST_LD_RD;
          else state_nxt = rgbsat_pkg::ST_Q_DONE;
        end
      end
      rgbsat_pkg::ST_LD_RD: if (step_r == 2'd3) state_nxt = rgbsat_pkg::ST_LD_WR;
      rgbsat_pkg::ST_LD_WR: state_nxt = rgbsat_pkg::ST_IDLE;
      rgbsat_pkg::ST_Q_RD: if (step_r == 2'd3) state_nxt = rgbsat_pkg::ST_Q_MUL;
      rgbsat_pkg::ST_Q_MUL: if (step_r == 2'd3) state_nxt = rgbsat_pkg::ST_Q_FIN;
      rgbsat_pkg::ST_Q_FIN: if (step_r == 2'd1) state_nxt = rgbsat_pkg::ST_IDLE;
      rgbsat_pkg::ST_Q_DONE: begin
        // decide query path
        if (!done_r || q_bad) begin
          state_nxt = rgbsat_pkg::ST_IDLE;
        end else begin
          state_nxt = rgbsat_pkg::ST_Q_RD;
          step_nxt  = '0;
        end
      end
      default: state_nxt = rgbsat_pkg::ST_IDLE;
    endcase
  end

  // result strobe: status error at the check, or finished statistics
  always_comb begin
    res_v_nxt = 1'b0;
    if (state_r == rgbsat_pkg::ST_Q_DONE && (!done_r || q_bad)) res_v_nxt = 1'b1;
    if (state_r == rgbsat_pkg::ST_Q_FIN && step_r == 2'd1) res_v_nxt = 1'b1;
  end

  // error result: status only, all other fields zero
  rgbsat_pkg::out_item_t err_res;
  always_comb begin
    err_res = '0;
    err_res.status = !done_r ? rgbsat_pkg::StatusNotDone : rgbsat_pkg::StatusOutside;
  end

  // shared multiplier operand: one channel sum per cycle
  always_comb begin
    case (step_r)
      2'd1: mul_a = acc_r.s_r;
      2'd2: mul_a = acc_r.s_g;
      default: mul_a = acc_r.s_b;
    endcase
  end

  logic [63:0] scaled_r, dev;
  always_comb begin
    dev = (scaled_r >= sq_acc_r) ? ((scaled_r - sq_acc_r) >> sh) : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rgbsat_pkg::ST_IDLE;
      step_r   <= '0;
      width_r  <= 9'd256;
      height_r <= 9'd256;
      col_r    <= '0;
      row_r    <= '0;
      done_r   <= 1'b0;
      res_v_r  <= 1'b0;
      mul_v_r  <= 1'b0;
      rd_ok_r  <= 1'b0;
    end else begin
      res_v_r <= res_v_nxt;
      rd_ok_r <= rd_ok;
      mul_v_r <= (state_r == rgbsat_pkg::ST_Q_MUL) && (step_r != 2'd0);
      state_r <= state_nxt;
      step_r  <= step_nxt;
      // position and completion: config restarts, a load clears and advances
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rgbsat_pkg::CfgWidth)
          width_r <= (cfg_data == '0) ? 9'd1 :
                     (cfg_data > 9'(rgbsat_pkg::MaxWidth)) ? 9'(rgbsat_pkg::MaxWidth) : cfg_data;
        else
          height_r <= (cfg_data == '0) ? 9'd1 :
                      (cfg_data > 9'(rgbsat_pkg::MaxHeight)) ? 9'(rgbsat_pkg::MaxHeight) : cfg_data;
        col_r  <= '0;
        row_r  <= '0;
        done_r <= 1'b0;
      end else if (we) begin
        if (9'(col_r) + 9'd1 >= width_r) begin
          col_r <= '0;
          if (9'(row_r) + 9'd1 >= height_r) begin
            row_r  <= '0;
            done_r <= 1'b1;
          end else row_r <= row_r + 8'd1;
        end else col_r <= col_r + 8'd1;
      end else if (state_r == rgbsat_pkg::ST_IDLE && start &&
                   in_item.op == rgbsat_pkg::OpLoad) begin
        done_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == rgbsat_pkg::ST_IDLE) begin
      item_r   <= in_item;
      acc_r    <= '0;
      sq_acc_r <= '0;
    end else begin
      if (take) begin
        if (sub_now) begin
          acc_r.s_r <= acc_r.s_r - rdata.s_r;  acc_r.s_g <= acc_r.s_g - rdata.s_g;
          acc_r.s_b <= acc_r.s_b - rdata.s_b;  acc_r.q_r <= acc_r.q_r - rdata.q_r;
          acc_r.q_g <= acc_r.q_g - rdata.q_g;  acc_r.q_b <= acc_r.q_b - rdata.q_b;
        end else begin
          acc_r.s_r <= acc_r.s_r + rdata.s_r;  acc_r.s_g <= acc_r.s_g + rdata.s_g;
          acc_r.s_b <= acc_r.s_b + rdata.s_b;  acc_r.q_r <= acc_r.q_r + rdata.q_r;
          acc_r.q_g <= acc_r.q_g + rdata.q_g;  acc_r.q_b <= acc_r.q_b + rdata.q_b;
        end
      end
      if (mul_v_r) sq_acc_r <= sq_acc_r + 64'(mul_p_r);
    end
    mul_p_r <= mul_a * mul_a;
    // scaled square sums, settled once the last corner is in
    if (state_r == rgbsat_pkg::ST_Q_MUL)
      scaled_r <= (64'(acc_r.q_r) + 64'(acc_r.q_g) + 64'(acc_r.q_b)) << sh;
    if (state_r == rgbsat_pkg::ST_Q_DONE) res_r <= err_res;
    if (state_r == rgbsat_pkg::ST_Q_FIN && step_r == 2'd1) begin
      res_r.status        <= rgbsat_pkg::StatusOk;
      res_r.sum_red       <= acc_r.s_r;
      res_r.sum_green     <= acc_r.s_g;
      res_r.sum_blue      <= acc_r.s_b;
      res_r.avg_red       <= 8'(acc_r.s_r >> sh);
      res_r.avg_green     <= 8'(acc_r.s_g >> sh);
      res_r.avg_blue      <= 8'(acc_r.s_b >> sh);
      res_r.deviation_sum <= dev[31:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready) else $error("cfg taken while busy");
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == rgbsat_pkg::ST_IDLE) else $error("result while busy");
  a_no_start_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item lost");
`endif

endmodule
